// File: src/paged_mono_framebuffer_engine_core_macros.svh
// Assertion macros shared by the checker of the paged framebuffer engine.
`ifndef PAGED_MONO_FRAMEBUFFER_ENGINE_CORE_MACROS_SVH
`define PAGED_MONO_FRAMEBUFFER_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, idle during reset.
`define PMFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define PMFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pmfb_pkg.sv
// Shared types and constants of the paged framebuffer engine.
package pmfb_pkg;

  // Input item kinds.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_PIXEL  = 2'd1,
    MODE_BITMAP = 2'd2,
    MODE_FLUSH  = 2'd3
  } mode_t;

  // Work kinds passed from front to back.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RMW_READ,
    ST_RMW_WRITE,
    ST_FLUSH_READ,
    ST_FLUSH_OUT
  } state_t;

  // One classified command: a draw touches up to eight columns col + i of one page.
  typedef struct packed {
    op_t        op;
    logic [2:0] page;
    logic [2:0] row;
    logic [7:0] col;
    logic [7:0] mask;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h02;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] PIXEL_PATTERN = 8'h80;
  localparam logic [3:0] PIXEL_COUNT   = 4'd1;
  localparam int         CMD_BYTES     = 3;
  localparam int         QUEUE_DEPTH   = 4;
  localparam int         QPTR_W        = $clog2(QUEUE_DEPTH);

endpackage

// File: src/pmfb_front.sv
// Front end: takes input items and turns them into clipped commands.
module pmfb_front
  import pmfb_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic       push,
  input  logic [1:0] mode,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] pattern,
  input  logic [3:0] bit_count,
  input  logic       q_full,
  input  logic       init_done,
  output logic       full,
  output cmd_wr_t    wr
);

  logic [7:0] pat;
  logic [3:0] cnt;
  logic [8:0] col_sum;
  logic [7:0] mask;
  logic       row_ok;
  logic       keep;

  // Build the column mask: pattern bit, count limit and right edge per column, and the row bound.
  always_comb begin
    pat    = (mode_t'(mode) == MODE_PIXEL) ? PIXEL_PATTERN : pattern;
    cnt    = (mode_t'(mode) == MODE_PIXEL) ? PIXEL_COUNT : bit_count;
    row_ok = (y < 8'(HEIGHT));
    col_sum = '0;
    for (int i = 0; i < 8; i++) begin
      col_sum = {1'b0, x} + 9'(i);
      mask[i] = pat[7 - i] && (4'(i) < cnt) && (col_sum < 9'(WIDTH)) && row_ok;
    end
  end

  // Classify the item; drop draws that touch nothing.
  always_comb begin
    wr.cmd.page = y[5:3];
    wr.cmd.row  = y[2:0];
    wr.cmd.col  = x;
    wr.cmd.mask = mask;
    unique case (mode_t'(mode))
      MODE_CLEAR: begin
        wr.cmd.op = OP_CLEAR;
        keep      = 1'b1;
      end
      MODE_PIXEL, MODE_BITMAP: begin
        wr.cmd.op = OP_DRAW;
        keep      = |mask;
      end
      MODE_FLUSH: begin
        wr.cmd.op = OP_FLUSH;
        keep      = 1'b1;
      end
      default: begin
        wr.cmd.op = OP_FLUSH;
        keep      = 1'b0;
      end
    endcase
    wr.push = push && !full && keep;
  end

  assign full = q_full || !init_done;

endmodule

// File: src/pmfb_queue.sv
// Command queue between front and back ends.
module pmfb_queue
  import pmfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_wr_t   wr,
  input  logic      pop,
  output cmd_head_t head,
  output logic      full
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  // Store pushed commands.
  always_ff @(posedge clk) begin
    if (wr.push) begin
      slots[wr_ptr] <= wr.cmd;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (!wr.push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

// File: src/pmfb_back.sv
// Back end: frame memory, clear sweep, read-modify-write draws and upload bytes.
module pmfb_back
  import pmfb_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_head_t head,
  output logic      q_pop,
  output logic      init_done,
  input  logic      pop,
  output logic      empty,
  output logic [7:0] out_byte,
  output logic      data_select,
  output logic      last
);

  localparam int PAGES       = (HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PAGES * WIDTH;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int LAST_OFF    = WIDTH + CMD_BYTES - 1;
  localparam int OFF_W       = $clog2(LAST_OFF + 1);

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rd_data;
  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] sweep_addr;
  logic [7:0]        rmw_mask;
  logic [7:0]        rmw_rest;
  logic [2:0]        idx;
  logic [PAGE_W-1:0] page_cnt;
  logic [OFF_W-1:0]  off_cnt;
  logic              out_valid;
  logic              sweep_end;
  logic              off_is_data;
  logic [ADDR_W-1:0] draw_addr;
  logic [ADDR_W-1:0] flush_addr;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [7:0]        mem_wdata;
  logic              out_load;
  logic [7:0]        byte_sel;

  // Pick the lowest column still to be drawn.
  always_comb begin
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (rmw_mask[i]) begin
        idx = 3'(i);
      end
    end
  end

  assign rmw_rest    = rmw_mask & (rmw_mask - 8'd1);
  assign sweep_end   = (sweep_addr == ADDR_W'(STORE_BYTES - 1));
  assign off_is_data = (off_cnt >= OFF_W'(CMD_BYTES));
  assign draw_addr   = ADDR_W'(int'(head.cmd.page) * WIDTH + int'(head.cmd.col) + int'(idx));
  assign flush_addr  = off_is_data
                     ? ADDR_W'(int'(page_cnt) * WIDTH + int'(off_cnt) - CMD_BYTES)
                     : '0;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        if (sweep_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.op)
            OP_CLEAR: state_next = ST_SWEEP;
            OP_DRAW:  state_next = ST_RMW_READ;
            OP_FLUSH: state_next = ST_FLUSH_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_RMW_READ:   state_next = ST_RMW_WRITE;
      ST_RMW_WRITE:  state_next = (rmw_rest == '0) ? ST_IDLE : ST_RMW_READ;
      ST_FLUSH_READ: state_next = ST_FLUSH_OUT;
      ST_FLUSH_OUT: begin
        if (!out_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls, queue pop and output load.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = draw_addr;
    mem_wdata = rd_data | 8'(8'd1 << head.cmd.row);
    q_pop     = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_addr;
        mem_wdata = '0;
        q_pop     = sweep_end && init_done;
      end
      ST_RMW_READ: begin
        mem_re = 1'b1;
      end
      ST_RMW_WRITE: begin
        mem_we = 1'b1;
        q_pop  = (rmw_rest == '0);
      end
      ST_FLUSH_READ: begin
        mem_re   = 1'b1;
        mem_addr = flush_addr;
      end
      ST_FLUSH_OUT: begin
        out_load = !out_valid;
        q_pop    = !out_valid;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Single-port frame memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Sequencer state, sweep address, draw mask and init flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      init_done  <= 1'b0;
      rmw_mask   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_addr <= sweep_end ? '0 : sweep_addr + 1'b1;
        if (sweep_end) init_done <= 1'b1;
      end
      if (state == ST_IDLE) begin
        rmw_mask <= head.cmd.mask;
      end else if (state == ST_RMW_WRITE) begin
        rmw_mask <= rmw_rest;
      end
    end
  end

  // Select the upload byte for the current position.
  always_comb begin
    if (off_cnt == OFF_W'(0)) begin
      byte_sel = CMD_PAGE_BASE + 8'(page_cnt);
    end else if (off_cnt == OFF_W'(1)) begin
      byte_sel = CMD_COL_LOW;
    end else if (off_cnt == OFF_W'(2)) begin
      byte_sel = CMD_COL_HIGH;
    end else begin
      byte_sel = rd_data;
    end
  end

  // Advance the upload position and hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_cnt  <= '0;
      off_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        if (off_cnt == OFF_W'(LAST_OFF)) begin
          off_cnt  <= '0;
          page_cnt <= (page_cnt == PAGE_W'(PAGES - 1)) ? '0 : page_cnt + 1'b1;
        end else begin
          off_cnt <= off_cnt + 1'b1;
        end
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte    <= byte_sel;
      data_select <= off_is_data;
      last        <= (page_cnt == PAGE_W'(PAGES - 1)) && (off_cnt == OFF_W'(LAST_OFF));
    end
  end

  assign empty = !out_valid;

endmodule

// File: src/paged_mono_framebuffer_engine_core.sv
// Top level of the paged monochrome framebuffer engine.
// The engine keeps a WIDTH x HEIGHT monochrome frame in a single-port memory of
// ceil(HEIGHT/8) * WIDTH bytes, one byte per column of each 8-row page, bit 0 on top.
// Items enter a 4-deep command queue and are carried out one at a time by the back
// end; a flush result waits in an output register while new items are still taken.
// Work per item: a pixel or bitmap byte takes one read and one write of the single
// memory port for each on-screen set pixel; a draw that sets no on-screen pixel is
// dropped at the front; a clear writes every byte of the memory, one byte per cycle;
// a flush tick presents one upload byte, and waits while the previous result is
// still held. After reset a clearing pass writes every byte of the memory (1024
// bytes at the default size) and runs with full held high.
module paged_mono_framebuffer_engine_core
  import pmfb_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] mode,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] pattern,
  input  logic [3:0] bit_count,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       data_select,
  output logic       last
);

  cmd_wr_t   wr;
  cmd_head_t head;
  logic      q_full;
  logic      q_pop;
  logic      init_done;

  // Classify incoming transfers.
  pmfb_front #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_front (
    .push     (push),
    .mode     (mode),
    .x        (x),
    .y        (y),
    .pattern  (pattern),
    .bit_count(bit_count),
    .q_full   (q_full),
    .init_done(init_done),
    .full     (full),
    .wr       (wr)
  );

  // Buffer commands between the two halves.
  pmfb_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .pop (q_pop),
    .head(head),
    .full(q_full)
  );

  // Execute commands against the frame memory.
  pmfb_back #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .data_select(data_select),
    .last       (last)
  );

endmodule

// File: src/pmfb_checker.sv
// Port-level checker of the paged framebuffer engine, bound to the top level.
`include "paged_mono_framebuffer_engine_core_macros.svh"

module pmfb_checker
  import pmfb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       data_select,
  input logic       last
);

  // Nothing to deliver right after reset.
  `PMFB_ASSERT_IMPL(a_empty_after_reset, $past(rst), empty, "result present after reset")

  // A waiting result holds until it is transferred.
  `PMFB_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(out_byte) && $stable(data_select) && $stable(last), "waiting result changed")

  // The final byte of an upload is always display data.
  `PMFB_ASSERT_IMPL(a_last_is_data, !empty && last, data_select, "last flag on a command byte")

  // Command bytes are page select or the fixed column address bytes.
  `PMFB_ASSERT_IMPL(a_cmd_byte, !empty && !data_select, out_byte == CMD_COL_LOW || out_byte == CMD_COL_HIGH || out_byte[7:4] == CMD_PAGE_BASE[7:4], "unexpected command byte")

endmodule

bind paged_mono_framebuffer_engine_core pmfb_checker u_pmfb_checker (.*);
